// File: rtl/pvd_pkg.sv
`default_nettype none

package pvd_pkg;

   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 64;
   localparam int CNT_W   = 4;
   localparam int INIT_W  = 7;

   localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

   localparam logic [1:0] SUB_WIDE32 = 2'b00;
   localparam logic [1:0] SUB_WIDE64 = 2'b01;
   localparam logic [1:0] SUB_NEG    = 2'b10;

   localparam logic [CNT_W-1:0] FOLLOW_WIDE32 = 4'd4;
   localparam logic [CNT_W-1:0] FOLLOW_WIDE64 = 4'd8;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'b00,
      KIND_NEG  = 2'b01,
      KIND_INV  = 2'b10
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      kind_type          kind;
      logic [CNT_W-1:0]  count;
      logic [INIT_W-1:0] init;
   } item_type;

endpackage

`default_nettype wire

// File: rtl/pvd_channels.sv
`default_nettype none

interface pvd_req_if import pvd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_buffer;

   modport source (output valid, output in_byte, output end_of_buffer, input ready);
   modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface pvd_rsp_if import pvd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [CNT_W-1:0]   bytes_used;
   logic               status;

   modport source (output valid, output value, output bytes_used, output status, input ready);
   modport sink (input valid, input value, input bytes_used, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/pvd_front.sv
`default_nettype none

module pvd_front import pvd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   pvd_req_if.sink     req_ch,
   output logic        q_valid,
   input  wire logic   q_ready,
   output item_type    q_item
);

   item_type   cls;
   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   logic [BYTE_W-1:0] b;

   // classify the first-byte form
   always_comb begin
      b         = req_ch.in_byte;
      cls.data  = b;
      cls.last  = req_ch.end_of_buffer;
      cls.kind  = KIND_LOAD;
      cls.count = '0;
      cls.init  = '0;
      if (!b[7]) begin
         cls.init = b[6:0];
      end else if (b[7:6] == 2'b10) begin
         cls.init  = INIT_W'(b[5:0]);
         cls.count = CNT_W'(1);
      end else if (b[7:5] == 3'b110) begin
         cls.init  = INIT_W'(b[4:0]);
         cls.count = CNT_W'(2);
      end else if (b[7:4] == 4'b1110) begin
         cls.init  = INIT_W'(b[3:0]);
         cls.count = CNT_W'(3);
      end else begin
         case (b[3:2])
            SUB_WIDE32: cls.count = FOLLOW_WIDE32;
            SUB_WIDE64: cls.count = FOLLOW_WIDE64;
            SUB_NEG:    cls.kind  = KIND_NEG;
            default: begin
               cls.kind = KIND_INV;
               cls.init = INIT_W'(b[1:0]);
            end
         endcase
      end
   end

   assign req_ch.ready = (fill_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (fill_ff != 2'd0);
   assign pop          = q_valid && q_ready;
   assign q_item       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pvd_back.sv
`default_nettype none

module pvd_back import pvd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   q_valid,
   output logic        q_ready,
   input  wire item_type q_item,
   pvd_rsp_if.source   rsp_ch
);

   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               inv_ff, inv_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic               status_ff, status_in;

   logic [CNT_W-1:0]   rem_new;
   logic [VALUE_W-1:0] acc_new;
   logic               inv_new;
   logic [CNT_W-1:0]   cnt_new;
   logic               done;
   logic               out_free;
   logic               take;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign q_ready  = out_free;
   assign take     = q_valid && out_free;

   always_comb begin
      rem_new = rem_ff;
      acc_new = acc_ff;
      inv_new = inv_ff;
      done    = 1'b0;
      cnt_new = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);
      if (rem_ff == '0) begin
         case (q_item.kind)
            KIND_LOAD: begin
               acc_new = VALUE_W'(q_item.init);
               rem_new = q_item.count;
               done    = (q_item.count == '0);
            end
            KIND_NEG: inv_new = ~inv_ff;
            KIND_INV: begin
               acc_new = ~VALUE_W'(q_item.init);
               done    = 1'b1;
            end
            default: ;
         endcase
      end else begin
         acc_new = {acc_ff[VALUE_W-BYTE_W-1:0], q_item.data};
         rem_new = rem_ff - CNT_W'(1);
         done    = (rem_ff == CNT_W'(1));
      end
   end

   always_comb begin
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      inv_in       = inv_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      value_in     = value_ff;
      used_in      = used_ff;
      status_in    = status_ff;
      if (take) begin
         if (done || q_item.last) begin
            out_valid_in = 1'b1;
            value_in     = done ? (inv_ff ? ~acc_new : acc_new) : '0;
            used_in      = cnt_new;
            status_in    = !done;
            rem_in       = '0;
            acc_in       = '0;
            inv_in       = 1'b0;
            cnt_in       = '0;
         end else begin
            rem_in = rem_new;
            acc_in = acc_new;
            inv_in = inv_new;
            cnt_in = cnt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         acc_ff       <= '0;
         inv_ff       <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         acc_ff       <= acc_in;
         inv_ff       <= inv_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      used_ff   <= used_in;
      status_ff <= status_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.value      = value_ff;
   assign rsp_ch.bytes_used = used_ff;
   assign rsp_ch.status     = status_ff;

endmodule

`default_nettype wire

// File: rtl/prefix_varint_decoder_top.sv
// A request that ends a value goes through the two-entry request queue and then the
// response register. Throughput: one byte per cycle, set by the accumulator update
// in the back end, while no response waits on a low rsp_ch.ready.
// Reset: synchronous, active high; empties the queue, clears the decode state and
// drops the response valid.
`default_nettype none

module prefix_varint_decoder_top import pvd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   pvd_req_if.sink   req_ch,
   pvd_rsp_if.source rsp_ch
);

   logic     q_valid;
   logic     q_ready;
   item_type q_item;

   pvd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item)
   );

   pvd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_item  (q_item),
      .rsp_ch  (rsp_ch)
   );

`ifndef ASSERT_OFF
   a_trunc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status |-> rsp_ch.value == '0)
      else $error("truncated response carries a nonzero value");

   a_used_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.bytes_used != '0)
      else $error("response reports zero bytes used");

   a_queue_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !q_valid && !rsp_ch.valid)
      else $error("queue or response not empty after reset");
`endif

endmodule

`default_nettype wire

// File: sim/prefix_varint_decoder_top_test.sv
`default_nettype none

module prefix_varint_decoder_top_test;
   import pvd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_TOTAL   = 1650;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 32;
   localparam int HOLD_START  = 1200;
   localparam int HOLD_LEN    = 400;
   localparam int CALM_START  = 2200;
   localparam int CALM_LEN    = 900;
   localparam int DRAIN_WAIT  = 8;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_TRUNC = 1'b1;

   typedef enum int {
      FORM_7, FORM_14, FORM_21, FORM_28, FORM_32, FORM_64, FORM_INV2
   } form_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } stream_byte_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [CNT_W-1:0]   bytes_used;
      logic               status;
   } decoded_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pvd_req_if req_ch ();
   pvd_rsp_if rsp_ch ();

   prefix_varint_decoder_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   stream_byte_type byte_queue[$];
   decoded_type     decoded_queue[$];

   logic [CNT_W-1:0]   follow_left = '0;
   logic [VALUE_W-1:0] shift_acc   = '0;
   logic               negate      = 1'b0;
   logic [CNT_W-1:0]   seen_count  = '0;

   int   error_count = 0;
   int   cycle_count = 0;
   int   tx_cycles   = 0;
   int   rx_cycles   = 0;
   logic req_fire    = 1'b0;

   stream_byte_type taken_byte;
   decoded_type     predicted;
   decoded_type     oldest;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_decode();
      follow_left = '0;
      shift_acc   = '0;
      negate      = 1'b0;
      seen_count  = '0;
   endfunction

   function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic last,
                                      output decoded_type res);
      bit done;
      done = 1'b0;
      res  = '0;
      if (seen_count != CNT_MAX)
         seen_count = seen_count + 1'b1;
      if (follow_left == '0) begin
         if (b[7] == 1'b0) begin
            shift_acc = {{(VALUE_W-7){1'b0}}, b[6:0]};
            done      = 1'b1;
         end else if (b[7:6] == 2'b10) begin
            shift_acc   = {{(VALUE_W-6){1'b0}}, b[5:0]};
            follow_left = 4'd1;
         end else if (b[7:5] == 3'b110) begin
            shift_acc   = {{(VALUE_W-5){1'b0}}, b[4:0]};
            follow_left = 4'd2;
         end else if (b[7:4] == 4'b1110) begin
            shift_acc   = {{(VALUE_W-4){1'b0}}, b[3:0]};
            follow_left = 4'd3;
         end else begin
            case (b[3:2])
               SUB_WIDE32: begin
                  shift_acc   = '0;
                  follow_left = FOLLOW_WIDE32;
               end
               SUB_WIDE64: begin
                  shift_acc   = '0;
                  follow_left = FOLLOW_WIDE64;
               end
               SUB_NEG: negate = ~negate;
               default: begin
                  shift_acc = ~{{(VALUE_W-2){1'b0}}, b[1:0]};
                  done      = 1'b1;
               end
            endcase
         end
      end else begin
         shift_acc   = {shift_acc[VALUE_W-BYTE_W-1:0], b};
         follow_left = follow_left - 1'b1;
         if (follow_left == '0)
            done = 1'b1;
      end

      if (done) begin
         res.value      = negate ? ~shift_acc : shift_acc;
         res.bytes_used = seen_count;
         res.status     = STATUS_DONE;
         clear_decode();
         return 1'b1;
      end
      if (last) begin
         res.value      = '0;
         res.bytes_used = seen_count;
         res.status     = STATUS_TRUNC;
         clear_decode();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic add_req(input logic [BYTE_W-1:0] data, input logic last);
      stream_byte_type sb;
      sb.data = data;
      sb.last = last;
      byte_queue.push_back(sb);
   endtask

   task automatic add_value(input int negs, input bit cut);
      logic [BYTE_W-1:0] seq[$];
      logic [BYTE_W-1:0] lead;
      logic [1:0]        low;
      form_type          form;
      int                follow;
      int                stop;
      int                i;
      for (i = 0; i < negs; i++) begin
         low = 2'($urandom_range(3));
         seq.push_back({4'hF, SUB_NEG, low});
      end
      lead = BYTE_W'($urandom_range(255));
      form = form_type'($urandom_range(6));
      case (form)
         FORM_7: begin
            seq.push_back({1'b0, lead[6:0]});
            follow = 0;
         end
         FORM_14: begin
            seq.push_back({2'b10, lead[5:0]});
            follow = 1;
         end
         FORM_21: begin
            seq.push_back({3'b110, lead[4:0]});
            follow = 2;
         end
         FORM_28: begin
            seq.push_back({4'b1110, lead[3:0]});
            follow = 3;
         end
         FORM_32: begin
            seq.push_back({4'hF, SUB_WIDE32, lead[1:0]});
            follow = int'(FOLLOW_WIDE32);
         end
         FORM_64: begin
            seq.push_back({4'hF, SUB_WIDE64, lead[1:0]});
            follow = int'(FOLLOW_WIDE64);
         end
         default: begin
            seq.push_back({6'b111111, lead[1:0]});
            follow = 0;
         end
      endcase
      for (i = 0; i < follow; i++)
         seq.push_back(BYTE_W'($urandom_range(255)));
      stop = seq.size() - 1;
      if (cut && seq.size() > 1)
         stop = $urandom_range(seq.size() - 2);
      for (i = 0; i <= stop; i++)
         add_req(seq[i], (i == stop) && (cut || $urandom_range(7) == 0));
   endtask

   initial begin
      int pick;
      int negs;
      int r;

      add_req(8'h00, 1'b0);
      add_req(8'h7F, 1'b1);
      add_req(8'h80, 1'b0); add_req(8'hFF, 1'b0);
      add_req(8'hDF, 1'b0); add_req(8'h00, 1'b0); add_req(8'hFF, 1'b0);
      add_req(8'hF8, 1'b0); add_req(8'hF8, 1'b0);
      add_req(8'hEF, 1'b0); add_req(8'hFF, 1'b0); add_req(8'hFF, 1'b0); add_req(8'hFF, 1'b0);
      add_req(8'hF0, 1'b0); add_req(8'hDE, 1'b0); add_req(8'hAD, 1'b0);
      add_req(8'hBE, 1'b0); add_req(8'hEF, 1'b0);
      add_req(8'hFC, 1'b0);
      add_req(8'hF8, 1'b0); add_req(8'hFF, 1'b0);
      add_req(8'hC1, 1'b0); add_req(8'h22, 1'b1);
      add_req(8'hF5, 1'b1);

      while (byte_queue.size() < REQ_TOTAL) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            add_req(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
         end else begin
            r = $urandom_range(99);
            if (r < 75)
               negs = 0;
            else if (r < 94)
               negs = $urandom_range(2, 1);
            else
               negs = $urandom_range(16, 8);
            add_value(negs, pick < 24);
         end
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (byte_queue.size() != 0 || decoded_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0)
         $display("prefix_varint_decoder_top_test: clean");
      else
         $display("prefix_varint_decoder_top_test: errors");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid         <= 1'b0;
         req_ch.in_byte       <= '0;
         req_ch.end_of_buffer <= 1'b0;
      end else begin
         tx_cycles <= tx_cycles + 1;
         if (!req_ch.valid || req_fire) begin
            if (byte_queue.size() != 0 &&
                ((tx_cycles >= CALM_START && tx_cycles < CALM_START + CALM_LEN) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               req_ch.valid         <= 1'b1;
               req_ch.in_byte       <= byte_queue[0].data;
               req_ch.end_of_buffer <= byte_queue[0].last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rx_cycles <= rx_cycles + 1;
         if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN)
            rsp_ch.ready <= 1'b0;
         else if (rx_cycles >= CALM_START && rx_cycles < CALM_START + CALM_LEN)
            rsp_ch.ready <= 1'b1;
         else
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         taken_byte = byte_queue.pop_front();
         if (decode_byte(taken_byte.data, taken_byte.last, predicted))
            decoded_queue.push_back(predicted);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (decoded_queue.size() == 0) begin
            $display("%0t: unexpected response value %h bytes_used %0d status %0d",
                     $time, rsp_ch.value, rsp_ch.bytes_used, rsp_ch.status);
            error_count++;
         end else begin
            oldest = decoded_queue.pop_front();
            if (rsp_ch.value !== oldest.value) begin
               $display("%0t: value expected %h, got %h", $time, oldest.value, rsp_ch.value);
               error_count++;
            end
            if (rsp_ch.bytes_used !== oldest.bytes_used) begin
               $display("%0t: bytes_used expected %0d, got %0d",
                        $time, oldest.bytes_used, rsp_ch.bytes_used);
               error_count++;
            end
            if (rsp_ch.status !== oldest.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $time, oldest.status, rsp_ch.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out", $time);
         $display("prefix_varint_decoder_top_test: errors");
         $finish;
      end
   end

endmodule

`default_nettype wire
